// File: rtl/dra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dra_pkg;

  typedef enum logic [1:0] {
    SL_FREE = 2'd0,
    SL_LIVE = 2'd1,
    SL_PEND = 2'd2,
    SL_DEF  = 2'd3
  } slot_state_e;

  typedef enum logic [2:0] {
    ACT_ALLOC       = 3'd0,
    ACT_RELEASE     = 3'd1,
    ACT_TOUCH       = 3'd2,
    ACT_COLLECT     = 3'd3,
    ACT_UPDATE      = 3'd4,
    ACT_READ        = 3'd5,
    ACT_SET_DEFAULT = 3'd6,
    ACT_CLEAR       = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HANDLE = 3'd1,
    ST_FULL       = 3'd2,
    ST_DEF_PROT   = 3'd3,
    ST_NOT_LIVE   = 3'd4,
    ST_SLOT_ZERO  = 3'd5
  } status_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SWEEP = 9'b000000010,
    S_CQ    = 9'b000000100,
    S_CS    = 9'b000001000,
    S_CW    = 9'b000010000,
    S_CEND  = 9'b000100000,
    S_AS    = 9'b001000000,
    S_AW    = 9'b010000000,
    S_SWR   = 9'b100000000
  } fsm_e;

  localparam logic [0:0] CFG_CAPACITY = 1'b0;
  localparam logic [0:0] CFG_RESERVE  = 1'b1;

  localparam logic [10:0] CFG_CAP_RESET = 11'd1024;

endpackage

`default_nettype wire

// File: rtl/dra_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module dra_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/deferred_release_slot_allocator.sv
// Channel   Handshake                   Payload
// command   start, busy                 action, slot_index, handle_generation, timeline,
//                                       new_value
// config    cfg_valid_i, cfg_ready_o    cfg_index_i, cfg_data_i
// result    done_o (one-cycle strobe)   status, out_index, out_generation, out_value,
//                                       reclaimed_count, live_total, pending_total
//
// Release, touch, update, read and set default read the slot, then check and write it back before the result.
// Collect walks the pending queue one queued slot at a time; allocate adds a free-stack pop and a slot write.
// Clear walks the slot table at one entry a cycle.
// After reset a clearing pass runs with busy high.
// Each word is handled by one sequencer around the slot table memory.
// The result is shown for one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module deferred_release_slot_allocator #(
  parameter int unsigned SLOTS      = 1024,
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned GEN_BITS   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action_i,
  input  wire logic [9:0]  slot_index_i,
  input  wire logic [31:0] handle_generation_i,
  input  wire logic [63:0] timeline_i,
  input  wire logic [63:0] new_value_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [9:0]       out_index_o,
  output logic [31:0]      out_generation_o,
  output logic [63:0]      out_value_o,
  output logic [10:0]      reclaimed_count_o,
  output logic [10:0]      live_total_o,
  output logic [10:0]      pending_total_o
);

  import dra_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned GB = GEN_BITS;
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned CAP_RST = (SLOTS < 1024) ? SLOTS : 1024;

  typedef struct packed {
    logic [1:0]    st;
    logic [GB-1:0] gen;
    logic [63:0]   ret;
    logic [63:0]   last;
    logic [VB-1:0] val;
  } slot_t;

  localparam int unsigned EW = $bits(slot_t);

  function automatic logic [GB-1:0] gen_next(input logic [GB-1:0] g);
    logic [GB-1:0] n;
    n = g + GB'(1);
    return (n == '0) ? GB'(1) : n;
  endfunction

  fsm_e          state_q;
  action_e       act_q;
  logic [9:0]    idx_q;
  logic [31:0]   gen_q;
  logic [63:0]   tl_q;
  logic [VB-1:0] val_q;
  logic [10:0]   cfg_cap_q;
  logic          cfg_res_q;
  logic [CW-1:0] cap_q;
  logic          res_q;
  logic [VB-1:0] default_q;
  logic [63:0]   completed_q;
  logic [CW-1:0] live_q;
  logic [CW-1:0] pend_q;
  logic [CW-1:0] top_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] wcnt_q;
  logic [CW-1:0] recl_q;
  logic [IW-1:0] cidx_q;
  logic          init_q;
  logic          done_q;
  logic [2:0]    status_q;
  logic [IW-1:0] oidx_q;
  logic [GB-1:0] ogen_q;
  logic [VB-1:0] oval_q;

  logic          slot_we, slot_re;
  logic [IW-1:0] slot_wa, slot_ra;
  slot_t         slot_wd;
  logic [EW-1:0] slot_rdata;
  slot_t         rd;
  logic          q_we, q_re, fs_we, fs_re;
  logic [IW-1:0] q_wa, q_ra, q_wd, q_rdata;
  logic [IW-1:0] fs_wa, fs_ra, fs_wd, fs_rdata;

  logic          accept;
  logic [31:0]   in_idx32, lidx32, cap32, cfg_cap32;
  logic          hok, live_like, due, sw_free;
  logic [63:0]   ret_max;
  logic [CW-1:0] sw_idx;
  logic [CW-1:0] top_m1;
  logic [2:0]    swr_status;
  logic [CW-1:0] cap_new;
  logic [31:0]   oidx32, recl32, live32, pend32;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign rd        = slot_t'(slot_rdata);
  assign in_idx32  = {22'd0, slot_index_i};
  assign lidx32    = {22'd0, idx_q};
  assign cap32     = 32'(cap_q);
  assign cfg_cap32 = 32'(cfg_cap_q);
  assign hok       = (lidx32 < cap32) && (32'(rd.gen) == gen_q);
  assign live_like = (rd.st == SL_LIVE) || (rd.st == SL_DEF);
  assign due       = (rd.st == SL_PEND) && (rd.ret <= completed_q);
  assign ret_max   = (tl_q > rd.last) ? tl_q : rd.last;
  assign sw_idx    = cnt_q - CW'(1);
  assign top_m1    = top_q - CW'(1);
  assign sw_free   = !((sw_idx == '0) && res_q) && (sw_idx < cap_q);

  always_comb begin
    if (cfg_cap32 == 32'd0) begin
      cap_new = CW'(1);
    end else if (cfg_cap32 > SLOTS) begin
      cap_new = CW'(SLOTS);
    end else begin
      cap_new = CW'(cfg_cap32);
    end
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_wa    = lidx32[IW-1:0];
    slot_wd    = rd;
    slot_re    = 1'b0;
    slot_ra    = in_idx32[IW-1:0];
    q_we       = 1'b0;
    q_wa       = wcnt_q[IW-1:0];
    q_wd       = cidx_q;
    q_re       = 1'b0;
    q_ra       = cnt_q[IW-1:0];
    fs_we      = 1'b0;
    fs_wa      = top_q[IW-1:0];
    fs_wd      = cidx_q;
    fs_re      = 1'b0;
    fs_ra      = sw_idx[IW-1:0];
    swr_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        slot_re = accept;
        if (action_e'(action_i) == ACT_SET_DEFAULT) begin
          slot_ra = '0;
        end
      end
      S_SWEEP: begin
        slot_re = (32'(cnt_q) < SLOTS);
        slot_ra = cnt_q[IW-1:0];
        if (cnt_q != '0) begin
          slot_we      = 1'b1;
          slot_wa      = sw_idx[IW-1:0];
          slot_wd.st   = ((sw_idx == '0) && res_q) ? SL_DEF : SL_FREE;
          slot_wd.gen  = init_q ? GB'(1) :
                         ((rd.st == SL_LIVE) || (rd.st == SL_PEND)) ? gen_next(rd.gen) :
                         rd.gen;
          slot_wd.ret  = '0;
          slot_wd.last = '0;
          slot_wd.val  = default_q;
          fs_we        = sw_free && (32'(top_q) != SLOTS);
          fs_wd        = sw_idx[IW-1:0];
        end
      end
      S_CQ: begin
        q_re = (cnt_q != pend_q);
      end
      S_CS: begin
        slot_re = 1'b1;
        slot_ra = q_rdata;
      end
      S_CW: begin
        if (due) begin
          slot_we      = 1'b1;
          slot_wa      = cidx_q;
          slot_wd.st   = SL_FREE;
          slot_wd.gen  = gen_next(rd.gen);
          slot_wd.ret  = '0;
          slot_wd.last = '0;
          slot_wd.val  = default_q;
          fs_we        = (32'(top_q) != SLOTS);
        end else begin
          q_we = 1'b1;
        end
      end
      S_CEND: begin
        fs_re = (act_q == ACT_ALLOC) && (top_q != '0);
        fs_ra = top_m1[IW-1:0];
      end
      S_AS: begin
        slot_re = 1'b1;
        slot_ra = fs_rdata;
      end
      S_AW: begin
        slot_we      = 1'b1;
        slot_wa      = cidx_q;
        slot_wd.st   = SL_LIVE;
        slot_wd.ret  = '0;
        slot_wd.last = '0;
        slot_wd.val  = val_q;
      end
      S_SWR: begin
        unique case (act_q)
          ACT_RELEASE: begin
            if (!hok) begin
              swr_status = ST_BAD_HANDLE;
            end else if ((idx_q == '0) && res_q && (rd.st == SL_DEF)) begin
              swr_status = ST_DEF_PROT;
            end else if (rd.st != SL_LIVE) begin
              swr_status = ST_NOT_LIVE;
            end else begin
              slot_we     = 1'b1;
              slot_wd.st  = SL_PEND;
              slot_wd.ret = ret_max;
              q_we        = (32'(pend_q) < SLOTS);
              q_wa        = pend_q[IW-1:0];
              q_wd        = lidx32[IW-1:0];
            end
          end
          ACT_TOUCH: begin
            if (!hok) begin
              swr_status = ST_BAD_HANDLE;
            end else if (rd.st != SL_LIVE) begin
              swr_status = ST_NOT_LIVE;
            end else begin
              slot_we      = 1'b1;
              slot_wd.last = ret_max;
            end
          end
          ACT_UPDATE: begin
            if (!hok || !live_like) begin
              swr_status = ST_BAD_HANDLE;
            end else if (idx_q == '0) begin
              swr_status = ST_SLOT_ZERO;
            end else begin
              slot_we     = 1'b1;
              slot_wd.val = val_q;
            end
          end
          ACT_READ: begin
            if (!hok || !live_like) begin
              swr_status = ST_BAD_HANDLE;
            end
          end
          ACT_SET_DEFAULT: begin
            slot_wa = '0;
            if (res_q && (rd.st == SL_DEF)) begin
              slot_we     = 1'b1;
              slot_wd.val = val_q;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      top_q       <= '0;
      pend_q      <= '0;
      live_q      <= CW'(1);
      res_q       <= 1'b1;
      cap_q       <= CW'(CAP_RST);
      cfg_cap_q   <= CFG_CAP_RESET;
      cfg_res_q   <= 1'b1;
      completed_q <= '0;
      default_q   <= '0;
      done_q      <= 1'b0;
      wcnt_q      <= '0;
      recl_q      <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_CAPACITY) begin
          cfg_cap_q <= cfg_data_i;
        end else begin
          cfg_res_q <= cfg_data_i[0];
        end
      end
      if (fs_we) begin
        top_q <= top_q + CW'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q <= action_e'(action_i);
            idx_q <= slot_index_i;
            gen_q <= handle_generation_i;
            tl_q  <= timeline_i;
            val_q <= new_value_i[VB-1:0];
            unique case (action_e'(action_i))
              ACT_CLEAR: begin
                cap_q       <= cap_new;
                res_q       <= cfg_res_q;
                cnt_q       <= '0;
                top_q       <= '0;
                pend_q      <= '0;
                live_q      <= cfg_res_q ? CW'(1) : '0;
                completed_q <= '0;
                state_q     <= S_SWEEP;
              end
              ACT_ALLOC, ACT_COLLECT: begin
                if (timeline_i > completed_q) begin
                  completed_q <= timeline_i;
                end
                cnt_q   <= '0;
                wcnt_q  <= '0;
                recl_q  <= '0;
                state_q <= S_CQ;
              end
              default: begin
                state_q <= S_SWR;
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (32'(cnt_q) == SLOTS) begin
            init_q <= 1'b0;
            if (!init_q) begin
              done_q   <= 1'b1;
              status_q <= ST_OK;
              oidx_q   <= '0;
              ogen_q   <= '0;
              oval_q   <= '0;
              recl_q   <= '0;
            end
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        S_CQ: begin
          state_q <= (cnt_q == pend_q) ? S_CEND : S_CS;
        end
        S_CS: begin
          cidx_q  <= q_rdata;
          state_q <= S_CW;
        end
        S_CW: begin
          if (due) begin
            recl_q <= recl_q + CW'(1);
          end else begin
            wcnt_q <= wcnt_q + CW'(1);
          end
          cnt_q   <= cnt_q + CW'(1);
          state_q <= S_CQ;
        end
        S_CEND: begin
          pend_q <= wcnt_q;
          if (fs_re) begin
            top_q   <= top_q - CW'(1);
            state_q <= S_AS;
          end else begin
            done_q   <= 1'b1;
            status_q <= (act_q == ACT_ALLOC) ? ST_FULL : ST_OK;
            oidx_q   <= '0;
            ogen_q   <= '0;
            oval_q   <= '0;
            state_q  <= S_IDLE;
          end
        end
        S_AS: begin
          cidx_q  <= fs_rdata;
          state_q <= S_AW;
        end
        S_AW: begin
          live_q   <= live_q + CW'(1);
          done_q   <= 1'b1;
          status_q <= ST_OK;
          oidx_q   <= cidx_q;
          ogen_q   <= rd.gen;
          oval_q   <= '0;
          state_q  <= S_IDLE;
        end
        S_SWR: begin
          done_q   <= 1'b1;
          status_q <= swr_status;
          oidx_q   <= '0;
          ogen_q   <= '0;
          recl_q   <= '0;
          oval_q   <= ((act_q == ACT_READ) && (swr_status == ST_OK)) ? rd.val : '0;
          if ((act_q == ACT_RELEASE) && (swr_status == ST_OK)) begin
            live_q <= live_q - CW'(1);
            if (q_we) begin
              pend_q <= pend_q + CW'(1);
            end
          end
          if (act_q == ACT_SET_DEFAULT) begin
            default_q <= val_q;
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  dra_mem #(.DEPTH(SLOTS), .DW(EW)) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_wa),
    .wdata_i (slot_wd),
    .re_i    (slot_re),
    .raddr_i (slot_ra),
    .rdata_o (slot_rdata)
  );

  dra_mem #(.DEPTH(SLOTS), .DW(IW)) u_pend_mem (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_wa),
    .wdata_i (q_wd),
    .re_i    (q_re),
    .raddr_i (q_ra),
    .rdata_o (q_rdata)
  );

  dra_mem #(.DEPTH(SLOTS), .DW(IW)) u_free_mem (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_wa),
    .wdata_i (fs_wd),
    .re_i    (fs_re),
    .raddr_i (fs_ra),
    .rdata_o (fs_rdata)
  );

  assign oidx32 = 32'(oidx_q);
  assign recl32 = 32'(recl_q);
  assign live32 = 32'(live_q);
  assign pend32 = 32'(pend_q);

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign out_index_o       = oidx32[9:0];
  assign out_generation_o  = 32'(ogen_q);
  assign out_value_o       = 64'(oval_q);
  assign reclaimed_count_o = recl32[10:0];
  assign live_total_o      = live32[10:0];
  assign pending_total_o   = pend32[10:0];

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(pend_q) + 32'(live_q)) <= SLOTS)
    else $error("live and pending counts exceed the table");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) <= SLOTS)
    else $error("free stack overflow");
`endif

endmodule

`default_nettype wire

// File: tb/deferred_release_slot_allocator_test.sv
`timescale 1ns / 1ps

module deferred_release_slot_allocator_test;
  import dra_pkg::*;

  localparam int NSLOT = 1024;
  localparam int LIMIT = 20000000;

  typedef struct {
    logic [2:0]  act;
    logic [9:0]  idx;
    logic [31:0] gen;
    logic [63:0] tl;
    logic [63:0] val;
  } word_t;

  typedef struct {
    logic [2:0]  status;
    logic [9:0]  oidx;
    logic [31:0] ogen;
    logic [63:0] oval;
    logic [10:0] recl;
    logic [10:0] live;
    logic [10:0] pend;
  } reply_t;

  typedef struct {
    action_e     act;
    logic [9:0]  idx;
    logic [31:0] gen;
    logic [63:0] tl;
    logic [63:0] val;
    int          want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] action_i = '0;
  logic [9:0] slot_index_i = '0;
  logic [31:0] handle_generation_i = '0;
  logic [63:0] timeline_i = '0;
  logic [63:0] new_value_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic [9:0] out_index_o;
  logic [31:0] out_generation_o;
  logic [63:0] out_value_o;
  logic [10:0] reclaimed_count_o;
  logic [10:0] live_total_o;
  logic [10:0] pending_total_o;

  deferred_release_slot_allocator dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  slot_state_e sl_state[NSLOT];
  logic [31:0] sl_gen[NSLOT];
  logic [63:0] sl_retire[NSLOT];
  logic [63:0] sl_last[NSLOT];
  logic [63:0] sl_val[NSLOT];
  logic [9:0]  free_stk[NSLOT];
  logic [9:0]  pend_q[NSLOT];
  int          free_top, pend_cnt, live_cnt;
  logic [63:0] done_time, dflt_val;
  logic [10:0] reg_cap;
  logic        reg_res;
  int          cap_act;
  bit          res_act;

  reply_t reply_q[$];
  int errors = 0;
  int n_items = 0;
  int n_replies = 0;
  int n_full = 0;
  int n_recl = 0;
  int cycles = 0;
  logic [63:0] tnow = 64'd0;

  function automatic logic [31:0] gen_bump(logic [31:0] g);
    logic [31:0] n;
    n = g + 32'd1;
    return (n == 32'd0) ? 32'd1 : n;
  endfunction

  function automatic void rebuild_table();
    int c;
    c = reg_cap;
    if (c == 0) c = 1;
    if (c > NSLOT) c = NSLOT;
    cap_act = c;
    res_act = reg_res;
    free_top = 0;
    pend_cnt = 0;
    live_cnt = 0;
    for (int i = 0; i < NSLOT; i++) begin
      if (sl_state[i] == SL_LIVE || sl_state[i] == SL_PEND) sl_gen[i] = gen_bump(sl_gen[i]);
      sl_retire[i] = '0;
      sl_last[i] = '0;
      sl_val[i] = dflt_val;
      if (i == 0 && res_act) begin
        sl_state[i] = SL_DEF;
        live_cnt++;
      end else begin
        sl_state[i] = SL_FREE;
        if (i < cap_act) begin
          free_stk[free_top] = 10'(i);
          free_top++;
        end
      end
    end
    done_time = '0;
  endfunction

  function automatic int collect_due(logic [63:0] t);
    int w, n;
    logic [9:0] s;
    w = 0;
    n = 0;
    if (t > done_time) done_time = t;
    for (int r = 0; r < pend_cnt; r++) begin
      s = pend_q[r];
      if (sl_state[s] == SL_PEND && sl_retire[s] <= done_time) begin
        sl_state[s] = SL_FREE;
        sl_retire[s] = '0;
        sl_last[s] = '0;
        sl_gen[s] = gen_bump(sl_gen[s]);
        sl_val[s] = dflt_val;
        if (free_top < NSLOT) begin
          free_stk[free_top] = s;
          free_top++;
        end
        n++;
      end else begin
        pend_q[w] = s;
        w++;
      end
    end
    pend_cnt = w;
    return n;
  endfunction

  function automatic bit handle_ok(logic [9:0] i, logic [31:0] g);
    return (int'(i) < cap_act) && (sl_gen[i] == g);
  endfunction

  function automatic reply_t predict(word_t c);
    reply_t r;
    logic [9:0] s;
    logic [9:0] i;
    r = '{default: '0};
    i = c.idx;
    case (action_e'(c.act))
      ACT_ALLOC: begin
        r.recl = 11'(collect_due(c.tl));
        if (free_top == 0) begin
          r.status = ST_FULL;
        end else begin
          free_top--;
          s = free_stk[free_top];
          sl_state[s] = SL_LIVE;
          sl_retire[s] = '0;
          sl_last[s] = '0;
          sl_val[s] = c.val;
          live_cnt++;
          r.oidx = s;
          r.ogen = sl_gen[s];
        end
      end
      ACT_RELEASE: begin
        if (!handle_ok(i, c.gen)) r.status = ST_BAD_HANDLE;
        else if (i == 0 && res_act && sl_state[0] == SL_DEF) r.status = ST_DEF_PROT;
        else if (sl_state[i] != SL_LIVE) r.status = ST_NOT_LIVE;
        else begin
          if (pend_cnt < NSLOT) begin
            pend_q[pend_cnt] = i;
            pend_cnt++;
          end
          sl_retire[i] = (c.tl > sl_last[i]) ? c.tl : sl_last[i];
          sl_state[i] = SL_PEND;
          live_cnt--;
        end
      end
      ACT_TOUCH: begin
        if (!handle_ok(i, c.gen)) r.status = ST_BAD_HANDLE;
        else if (sl_state[i] != SL_LIVE) r.status = ST_NOT_LIVE;
        else if (c.tl > sl_last[i]) sl_last[i] = c.tl;
      end
      ACT_COLLECT: r.recl = 11'(collect_due(c.tl));
      ACT_UPDATE: begin
        if (!handle_ok(i, c.gen) || (sl_state[i] != SL_LIVE && sl_state[i] != SL_DEF))
          r.status = ST_BAD_HANDLE;
        else if (i == 0) r.status = ST_SLOT_ZERO;
        else sl_val[i] = c.val;
      end
      ACT_READ: begin
        if (!handle_ok(i, c.gen) || (sl_state[i] != SL_LIVE && sl_state[i] != SL_DEF))
          r.status = ST_BAD_HANDLE;
        else r.oval = sl_val[i];
      end
      ACT_SET_DEFAULT: begin
        dflt_val = c.val;
        if (res_act && sl_state[0] == SL_DEF) sl_val[0] = c.val;
      end
      default: rebuild_table();
    endcase
    r.live = 11'(live_cnt);
    r.pend = 11'(pend_cnt);
    return r;
  endfunction

  function automatic word_t rand_word();
    word_t c;
    int p;
    logic [9:0] s;
    p = $urandom_range(0, 99);
    c.act = (p < 25) ? ACT_ALLOC : (p < 45) ? ACT_RELEASE : (p < 55) ? ACT_TOUCH :
            (p < 67) ? ACT_COLLECT : (p < 77) ? ACT_UPDATE : (p < 89) ? ACT_READ :
            (p < 94) ? ACT_SET_DEFAULT : (p < 95) ? ACT_CLEAR : 3'($urandom);
    s = 10'($urandom_range(0, cap_act - 1));
    for (int k = 0; k < 8 && sl_state[s] != SL_LIVE; k++) begin
      s = 10'($urandom_range(0, cap_act - 1));
    end
    if ($urandom_range(0, 99) < 85) c.idx = s;
    else c.idx = 10'($urandom);
    p = $urandom_range(0, 9);
    c.gen = (p < 8) ? sl_gen[c.idx] : (p == 8) ? sl_gen[c.idx] - 32'd1 : $urandom;
    tnow = tnow + $urandom_range(0, 3);
    case (action_e'(c.act))
      ACT_RELEASE: c.tl = tnow + $urandom_range(0, 20);
      ACT_TOUCH:   c.tl = tnow + $urandom_range(0, 30);
      default:     c.tl = tnow;
    endcase
    if ($urandom_range(0, 99) == 0) c.tl = {$urandom, $urandom};
    c.val = {$urandom, $urandom};
    return c;
  endfunction

  task automatic send_word(word_t c, int want);
    int gap;
    reply_t r;
    gap = ($urandom_range(0, 9) < 3) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    action_i <= c.act;
    slot_index_i <= c.idx;
    handle_generation_i <= c.gen;
    timeline_i <= c.tl;
    new_value_i <= c.val;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    r = predict(c);
    if (want >= 0) r.status = 3'(want);
    if (r.status == ST_FULL) n_full++;
    n_recl += r.recl;
    reply_q = {reply_q, r};
    n_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [10:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    if (idx == CFG_CAPACITY) reg_cap = data;
    else reg_res = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && done_o) begin
      n_replies++;
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word, status %0d", status_o);
      end else begin
        e = reply_q.pop_front();
        if (status_o !== e.status || out_index_o !== e.oidx || out_generation_o !== e.ogen ||
            out_value_o !== e.oval || reclaimed_count_o !== e.recl ||
            live_total_o !== e.live || pending_total_o !== e.pend) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st %0d idx %0d gen %0h val %0h recl %0d live %0d pend %0d",
                     e.status, e.oidx, e.ogen, e.oval, e.recl, e.live, e.pend,
                     " / got st %0d idx %0d gen %0h val %0h recl %0d live %0d pend %0d",
                     status_o, out_index_o, out_generation_o, out_value_o,
                     reclaimed_count_o, live_total_o, pending_total_o);
        end
      end
    end
  end

  dir_row_t dir_tab[19] = '{
    '{ACT_READ,        10'd0,    32'd1, 64'd0, 64'd0, int'(ST_OK)},
    '{ACT_UPDATE,      10'd0,    32'd1, 64'd0, 64'd7, int'(ST_SLOT_ZERO)},
    '{ACT_RELEASE,     10'd0,    32'd1, 64'd0, 64'd0, int'(ST_DEF_PROT)},
    '{ACT_TOUCH,       10'd0,    32'd1, 64'd5, 64'd0, int'(ST_NOT_LIVE)},
    '{ACT_READ,        10'd5,    32'd0, 64'd0, 64'd0, int'(ST_BAD_HANDLE)},
    '{ACT_RELEASE,     10'd5,    32'd1, 64'd0, 64'd0, int'(ST_NOT_LIVE)},
    '{ACT_ALLOC,       10'd0,    32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, int'(ST_OK)},
    '{ACT_TOUCH,       10'd1023, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, int'(ST_OK)},
    '{ACT_RELEASE,     10'd1023, 32'd1, 64'd0, 64'd0, int'(ST_OK)},
    '{ACT_COLLECT,     10'd0,    32'd0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, int'(ST_OK)},
    '{ACT_COLLECT,     10'd0,    32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, int'(ST_OK)},
    '{ACT_READ,        10'd1023, 32'd1, 64'd0, 64'd0, int'(ST_BAD_HANDLE)},
    '{ACT_SET_DEFAULT, 10'd0,    32'd0, 64'd0, 64'h5A5A_A5A5_0F0F_F0F0, int'(ST_OK)},
    '{ACT_READ,        10'd0,    32'd1, 64'd0, 64'd0, int'(ST_OK)},
    '{ACT_ALLOC,       10'd0,    32'd0, 64'd0, 64'd0, int'(ST_OK)},
    '{ACT_UPDATE,      10'd1023, 32'd2, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, int'(ST_OK)},
    '{ACT_READ,        10'd1023, 32'd2, 64'd0, 64'd0, int'(ST_OK)},
    '{ACT_READ,        10'd1023, 32'hFFFF_FFFF, 64'd0, 64'd0, int'(ST_BAD_HANDLE)},
    '{ACT_CLEAR,       10'd0,    32'd0, 64'd0, 64'd0, int'(ST_OK)}
  };

  initial begin
    word_t c;
    int per_phase;
    logic [10:0] caps[6];
    bit ress[6];
    logic [10:0] cap_w;
    bit res_w;

    caps = '{11'd1, 11'd0, 11'd2, 11'd2047, 11'd1024, 11'd1024};
    ress = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    reg_cap = CFG_CAP_RESET;
    reg_res = 1'b1;
    dflt_val = '0;
    for (int i = 0; i < NSLOT; i++) begin
      sl_state[i] = SL_FREE;
      sl_gen[i] = 32'd1;
    end
    rebuild_table();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      c.act = dir_tab[k].act;
      c.idx = dir_tab[k].idx;
      c.gen = dir_tab[k].gen;
      c.tl = dir_tab[k].tl;
      c.val = dir_tab[k].val;
      send_word(c, dir_tab[k].want);
    end

    per_phase = 120;
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      if (p < 6) begin
        cap_w = caps[p];
        res_w = ress[p];
      end else begin
        cap_w = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(1, 48));
        res_w = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_CAPACITY, cap_w);
        write_reg(CFG_RESERVE, res_w);
      end else begin
        write_reg(CFG_RESERVE, res_w);
        write_reg(CFG_CAPACITY, cap_w);
      end
      c = '{act: ACT_CLEAR, idx: '0, gen: '0, tl: '0, val: '0};
      send_word(c, -1);
      tnow = '0;
      for (int k = 0; k < per_phase; k++) send_word(rand_word(), -1);
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d command words, %0d results, %0d full allocations, %0d slots reclaimed.",
             n_items, n_replies, n_full, n_recl);
    $display("Mismatches: %0d, results still outstanding: %0d.", errors, reply_q.size());
    if (errors == 0 && reply_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
